FILE: rtl/two_sided_wall_span_clipper_assert.svh
// assertion macros for the span clipper
`ifndef TWO_SIDED_WALL_SPAN_CLIPPER_ASSERT_SVH
`define TWO_SIDED_WALL_SPAN_CLIPPER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SWSC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SWSC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SWSC_ASSERT(lbl, clk, rstn, prop, msg)
`define SWSC_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

FILE: rtl/swsc_pkg.sv
package swsc_pkg;

  localparam int unsigned COLUMNS_DEF       = 64;
  localparam int unsigned ROWS_DEF          = 160;
  localparam int unsigned FRACTION_BITS_DEF = 12;

  localparam int unsigned ROW_W     = 8;
  localparam int unsigned COL_W     = 6;
  localparam int unsigned X_W       = 7;
  localparam int unsigned Y_W       = 32;
  localparam int unsigned SPAN_W    = 16;
  localparam int unsigned WIDE_W    = 17;
  localparam int unsigned DIFF_W    = 33;
  localparam int unsigned QUO_W     = 32;
  localparam int unsigned DIVISOR_W = 16;
  localparam int unsigned SLOPE_W   = 33;
  localparam int unsigned PROD_W    = 50;
  localparam int unsigned POS_W     = 56;
  localparam int unsigned EDGES     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [ROW_W-1:0] CLEAR_TOP_RESET    = 8'd4;
  localparam logic [ROW_W-1:0] CLEAR_BOTTOM_RESET = 8'd155;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_SPAN  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    EDGE_FRONT_CEIL  = 2'd0,
    EDGE_BACK_CEIL   = 2'd1,
    EDGE_FRONT_FLOOR = 2'd2,
    EDGE_BACK_FLOOR  = 2'd3
  } edge_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLEAR_TOP    = 2'd0,
    CFG_CLEAR_BOTTOM = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_DIV,
    ST_MUL,
    ST_POS,
    ST_WALK
  } back_state_e;

  typedef struct packed {
    kind_e                    kind;
    logic [1:0]               edge_index;
    logic signed [Y_W-1:0]    edge_start_y;
    logic signed [Y_W-1:0]    edge_end_y;
    logic signed [SPAN_W-1:0] span_left;
    logic signed [SPAN_W-1:0] span_right;
    logic [X_W-1:0]           draw_left;
    logic [X_W-1:0]           draw_right;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] ceiling_top;
    logic [ROW_W-1:0] ceiling_end;
    logic [ROW_W-1:0] upper_step_end;
    logic [ROW_W-1:0] lower_step_start;
    logic [ROW_W-1:0] floor_start;
    logic [ROW_W-1:0] floor_end;
    logic             border;
    logic             last;
  } result_t;

  typedef struct packed {
    kind_e                    kind;
    logic [1:0]               edge_index;
    logic signed [Y_W-1:0]    start_y;
    logic signed [Y_W-1:0]    end_y;
    logic signed [WIDE_W-1:0] width;
    logic signed [WIDE_W-1:0] adv;
    logic [X_W-1:0]           left;
    logic [X_W-1:0]           right;
    logic [X_W-1:0]           stop;
  } cmd_t;

  typedef struct packed {
    logic                 start;
    logic [QUO_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/two_sided_wall_span_clipper.sv
// channel   direction  handshake            payload
// items     in         push / full          item_i (swsc_pkg::in_item_t)
// results   out        pop / empty          result_o (swsc_pkg::result_t)
// config    in         valid / ready        cfg_index_i, cfg_data_i
//
// clear and edge-load items are handled in the idle state of the back end
// a span runs each edge through the shared bit-serial divider (none for zero width), then the
// multiply and start positions, then one drawn column per cycle through the clip store
// the front keeps taking items into a two-entry queue while the back end works
// result stalls hold the column walk; the store needs no pass after reset
`include "two_sided_wall_span_clipper_assert.svh"

module two_sided_wall_span_clipper #(
  parameter int unsigned COLUMNS       = swsc_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS          = swsc_pkg::ROWS_DEF,
  parameter int unsigned FRACTION_BITS = swsc_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  swsc_pkg::in_item_t                item_i,
  output logic                              empty,
  input  logic                              pop,
  output swsc_pkg::result_t                 result_o,
  input  logic                              valid,
  output logic                              ready,
  input  logic [swsc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [swsc_pkg::CFG_DAT_W-1:0]    cfg_data_i
);

  logic [swsc_pkg::ROW_W-1:0] cfg_top_q, cfg_bot_q;
  swsc_pkg::cmd_t             front_cmd, back_cmd;
  swsc_pkg::result_t          res;
  logic                       cmd_push, cmd_pop, cmd_empty, res_push, res_full;

  assign ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_top_q <= swsc_pkg::CLEAR_TOP_RESET;
      cfg_bot_q <= swsc_pkg::CLEAR_BOTTOM_RESET;
    end else if (valid && ready) begin
      case (cfg_index_i)
        swsc_pkg::CFG_CLEAR_TOP:    cfg_top_q <= cfg_data_i;
        swsc_pkg::CFG_CLEAR_BOTTOM: cfg_bot_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  swsc_front #(
    .COLUMNS (COLUMNS)
  ) u_front (
    .item_i     (item_i),
    .accept_i   (push && !full),
    .cmd_o      (front_cmd),
    .cmd_push_o (cmd_push)
  );

  swsc_fifo #(
    .T     (swsc_pkg::cmd_t),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .full_o  (full),
    .empty_o (cmd_empty)
  );

  swsc_back #(
    .COLUMNS       (COLUMNS),
    .ROWS          (ROWS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_top_i    (cfg_top_q),
    .cfg_bottom_i (cfg_bot_q),
    .cmd_i        (back_cmd),
    .cmd_empty_i  (cmd_empty),
    .cmd_pop_o    (cmd_pop),
    .res_o        (res),
    .res_push_o   (res_push),
    .res_full_i   (res_full)
  );

  swsc_fifo #(
    .T     (swsc_pkg::result_t),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .pop_i   (pop && !empty),
    .data_o  (result_o),
    .full_o  (res_full),
    .empty_o (empty)
  );

  `SWSC_ASSERT(a_step_order, clk_i, rst_ni, !empty |-> ((result_o.lower_step_start >= result_o.ceiling_end) && (result_o.upper_step_end <= result_o.floor_start)), "step rows out of order")
  `SWSC_ASSERT(a_fill_in_clip, clk_i, rst_ni, (!empty && (result_o.ceiling_top <= result_o.floor_end)) |-> ((result_o.ceiling_top <= result_o.ceiling_end) && (result_o.floor_start <= result_o.floor_end)), "fill rows outside clip range")
  `SWSC_ASSERT_NEVER(a_column_range, clk_i, rst_ni, !empty && ({1'b0, result_o.column} >= 7'(COLUMNS)), "column beyond clip store")

endmodule

FILE: rtl/swsc_fifo.sv
module swsc_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  input  logic pop_i,
  output T     data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  T              mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (AW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (AW+1)'(1);
      end
    end
  end

endmodule

FILE: rtl/swsc_front.sv
module swsc_front #(
  parameter int unsigned COLUMNS = swsc_pkg::COLUMNS_DEF
) (
  input  swsc_pkg::in_item_t item_i,
  input  logic               accept_i,
  output swsc_pkg::cmd_t     cmd_o,
  output logic               cmd_push_o
);

  localparam logic [swsc_pkg::X_W-1:0] COL_LIM = swsc_pkg::X_W'(COLUMNS);

  logic [swsc_pkg::X_W-1:0] stop;
  logic                     keep;

  always_comb begin
    stop = (item_i.draw_right > COL_LIM) ? COL_LIM : item_i.draw_right;
    cmd_o.kind       = item_i.kind;
    cmd_o.edge_index = item_i.edge_index;
    cmd_o.start_y    = item_i.edge_start_y;
    cmd_o.end_y      = item_i.edge_end_y;
    cmd_o.width      = swsc_pkg::WIDE_W'(item_i.span_right) - swsc_pkg::WIDE_W'(item_i.span_left);
    cmd_o.adv        = $signed({10'd0, item_i.draw_left})
                     - swsc_pkg::WIDE_W'(item_i.span_left);
    cmd_o.left       = item_i.draw_left;
    cmd_o.right      = item_i.draw_right;
    cmd_o.stop       = stop;
    case (item_i.kind)
      swsc_pkg::KIND_CLEAR: keep = 1'b1;
      swsc_pkg::KIND_LOAD:  keep = 1'b1;
      swsc_pkg::KIND_SPAN:  keep = (item_i.draw_left < stop);
      default:              keep = 1'b0;
    endcase
  end

  assign cmd_push_o = accept_i && keep;

endmodule

FILE: rtl/swsc_div.sv
module swsc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swsc_pkg::div_req_t req_i,
  output swsc_pkg::div_rsp_t rsp_o
);

  localparam int unsigned QW = swsc_pkg::QUO_W;
  localparam int unsigned DW = swsc_pkg::DIVISOR_W;
  localparam int unsigned CW = $clog2(QW);

  logic [QW-1:0] quo_q;
  logic [DW-1:0] rem_q, div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   rem_sh, rem_sub;
  logic          ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[QW-1]};
    ge      = (rem_sh >= {1'b0, div_q});
    rem_sub = rem_sh - {1'b0, div_q};
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      div_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[QW-2:0], ge};
      rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(QW - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(QW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: rtl/swsc_back.sv
module swsc_back #(
  parameter int unsigned COLUMNS       = swsc_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS          = swsc_pkg::ROWS_DEF,
  parameter int unsigned FRACTION_BITS = swsc_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [swsc_pkg::ROW_W-1:0]    cfg_top_i,
  input  logic [swsc_pkg::ROW_W-1:0]    cfg_bottom_i,
  input  swsc_pkg::cmd_t                cmd_i,
  input  logic                          cmd_empty_i,
  output logic                          cmd_pop_o,
  output swsc_pkg::result_t             res_o,
  output logic                          res_push_o,
  input  logic                          res_full_i
);

  localparam int unsigned RW = swsc_pkg::ROW_W;
  localparam int unsigned XW = swsc_pkg::X_W;
  localparam int unsigned PW = swsc_pkg::POS_W;
  localparam int unsigned SW = swsc_pkg::SLOPE_W;
  localparam int unsigned CW = $clog2(COLUMNS);
  localparam logic [RW-1:0] ROW_MAX = RW'(ROWS - 1);
  localparam logic [RW-1:0] RST_TOP = (swsc_pkg::CLEAR_TOP_RESET > ROW_MAX)
                                      ? ROW_MAX : swsc_pkg::CLEAR_TOP_RESET;
  localparam logic [RW-1:0] RST_BOT = (swsc_pkg::CLEAR_BOTTOM_RESET > ROW_MAX)
                                      ? ROW_MAX : swsc_pkg::CLEAR_BOTTOM_RESET;
  localparam logic [XW-1:0] LAST_COL = XW'(COLUMNS - 1);

  function automatic logic [RW-1:0] clamp_row(logic signed [PW-1:0] v,
                                              logic [RW-1:0] lo, logic [RW-1:0] hi);
    logic signed [PW-1:0] lo_s, hi_s, t;
    lo_s = $signed({{(PW-RW){1'b0}}, lo});
    hi_s = $signed({{(PW-RW){1'b0}}, hi});
    t    = (v < lo_s) ? lo_s : v;
    t    = (t > hi_s) ? hi_s : t;
    return t[RW-1:0];
  endfunction

  swsc_pkg::back_state_e state_q, state_d;

  logic signed [swsc_pkg::Y_W-1:0]    start_q [swsc_pkg::EDGES];
  logic signed [swsc_pkg::Y_W-1:0]    end_q   [swsc_pkg::EDGES];
  logic signed [SW-1:0]               slope_q [swsc_pkg::EDGES];
  logic signed [PW-1:0]               pos_q   [swsc_pkg::EDGES];
  logic signed [swsc_pkg::PROD_W-1:0] prod_q;
  logic [1:0]                         e_q;
  logic                               qneg_q;
  logic signed [swsc_pkg::WIDE_W-1:0] width_q, adv_q;
  logic [XW-1:0]                      left_q, right_q, stop_q;
  logic [RW-1:0]                      clr_top_q, clr_bot_q;
  logic [COLUMNS-1:0]                 vld_q;

  logic [RW-1:0] top_mem [COLUMNS];
  logic [RW-1:0] bot_mem [COLUMNS];
  logic [RW-1:0] rd_top_q, rd_bot_q;
  logic          rd_vld_q;

  logic [XW-1:0] issue_x_q, b_x_q;
  logic          b_vld_q;

  swsc_pkg::div_req_t div_req;
  swsc_pkg::div_rsp_t div_rsp;

  logic signed [swsc_pkg::DIFF_W-1:0] diff;
  logic [swsc_pkg::DIFF_W-1:0]        dmag;
  logic [swsc_pkg::WIDE_W-1:0]        wmag;
  logic signed [SW-1:0]               slope_new;
  logic                               issue_ok, rd_adv, b_fire, b_last, edge_last;
  logic [RW-1:0]                      top, bot, cya, cnya, cyb, cnyb, mx, mn, new_top, new_bot;

  swsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    diff      = swsc_pkg::DIFF_W'(end_q[e_q]) - swsc_pkg::DIFF_W'(start_q[e_q]);
    dmag      = diff[swsc_pkg::DIFF_W-1] ? swsc_pkg::DIFF_W'(-diff) : diff;
    wmag      = width_q[swsc_pkg::WIDE_W-1] ? swsc_pkg::WIDE_W'(-width_q) : width_q;
    div_req.start    = (state_q == swsc_pkg::ST_DIFF) && (width_q != '0);
    div_req.dividend = dmag[swsc_pkg::QUO_W-1:0];
    div_req.divisor  = wmag[swsc_pkg::DIVISOR_W-1:0];
    slope_new = qneg_q ? -$signed({1'b0, div_rsp.quotient})
                       : $signed({1'b0, div_rsp.quotient});
    edge_last = (e_q == 2'(swsc_pkg::EDGE_BACK_FLOOR));
  end

  // column walk: read stage then update stage
  always_comb begin
    issue_ok = (state_q == swsc_pkg::ST_WALK) && (issue_x_q < stop_q);
    b_fire   = b_vld_q && !res_full_i;
    rd_adv   = !b_vld_q || b_fire;
    b_last   = ({1'b0, b_x_q} + 8'd1) == {1'b0, stop_q};
    top      = rd_vld_q ? rd_top_q : clr_top_q;
    bot      = rd_vld_q ? rd_bot_q : clr_bot_q;
    cya      = clamp_row(pos_q[swsc_pkg::EDGE_FRONT_CEIL]  >>> FRACTION_BITS, top, bot);
    cnya     = clamp_row(pos_q[swsc_pkg::EDGE_BACK_CEIL]   >>> FRACTION_BITS, top, bot);
    cyb      = clamp_row(pos_q[swsc_pkg::EDGE_FRONT_FLOOR] >>> FRACTION_BITS, top, bot);
    cnyb     = clamp_row(pos_q[swsc_pkg::EDGE_BACK_FLOOR]  >>> FRACTION_BITS, top, bot);
    if (cnyb < cya) begin
      cnyb = cya;
    end
    if (cnya > cyb) begin
      cnya = cyb;
    end
    mx      = (cya > cnya) ? cya : cnya;
    new_top = (mx < top) ? top : mx;
    new_top = (new_top > ROW_MAX) ? ROW_MAX : new_top;
    mn      = (cyb < cnyb) ? cyb : cnyb;
    new_bot = (mn > bot) ? bot : mn;

    res_o.column           = b_x_q[swsc_pkg::COL_W-1:0];
    res_o.ceiling_top      = top;
    res_o.ceiling_end      = cya;
    res_o.upper_step_end   = cnya;
    res_o.lower_step_start = cnyb;
    res_o.floor_start      = cyb;
    res_o.floor_end        = bot;
    res_o.border           = (b_x_q == left_q) || (b_x_q == '0) || (b_x_q == LAST_COL)
                          || (({1'b0, b_x_q} + 8'd1) == {1'b0, right_q});
    res_o.last             = b_last;
    res_push_o             = b_fire;
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    case (state_q)
      swsc_pkg::ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == swsc_pkg::KIND_SPAN) begin
            state_d = swsc_pkg::ST_DIFF;
          end
        end
      end
      swsc_pkg::ST_DIFF: begin
        if (width_q != '0) begin
          state_d = swsc_pkg::ST_DIV;
        end else if (edge_last) begin
          state_d = swsc_pkg::ST_MUL;
        end
      end
      swsc_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_d = edge_last ? swsc_pkg::ST_MUL : swsc_pkg::ST_DIFF;
        end
      end
      swsc_pkg::ST_MUL: state_d = swsc_pkg::ST_POS;
      swsc_pkg::ST_POS: state_d = edge_last ? swsc_pkg::ST_WALK : swsc_pkg::ST_MUL;
      swsc_pkg::ST_WALK: begin
        if (b_fire && b_last) begin
          state_d = swsc_pkg::ST_IDLE;
        end
      end
      default: state_d = swsc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      swsc_pkg::ST_IDLE: begin
        if (cmd_pop_o) begin
          if (cmd_i.kind == swsc_pkg::KIND_LOAD) begin
            start_q[cmd_i.edge_index] <= cmd_i.start_y;
            end_q[cmd_i.edge_index]   <= cmd_i.end_y;
          end
          width_q   <= cmd_i.width;
          adv_q     <= cmd_i.adv;
          left_q    <= cmd_i.left;
          right_q   <= cmd_i.right;
          stop_q    <= cmd_i.stop;
          issue_x_q <= cmd_i.left;
          e_q       <= '0;
        end
      end
      swsc_pkg::ST_DIFF: begin
        qneg_q <= diff[swsc_pkg::DIFF_W-1] ^ width_q[swsc_pkg::WIDE_W-1];
        if (width_q == '0) begin
          slope_q[e_q] <= '0;
          e_q          <= e_q + 2'd1;
        end
      end
      swsc_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          slope_q[e_q] <= slope_new;
          e_q          <= e_q + 2'd1;
        end
      end
      swsc_pkg::ST_MUL: begin
        prod_q <= slope_q[e_q] * adv_q;
      end
      swsc_pkg::ST_POS: begin
        pos_q[e_q] <= PW'(start_q[e_q]) + PW'(prod_q);
        e_q        <= e_q + 2'd1;
      end
      swsc_pkg::ST_WALK: begin
        if (rd_adv && issue_ok) begin
          issue_x_q <= issue_x_q + XW'(1);
          b_x_q     <= issue_x_q;
        end
        if (b_fire) begin
          for (int i = 0; i < swsc_pkg::EDGES; i++) begin
            pos_q[i] <= pos_q[i] + PW'(slope_q[i]);
          end
        end
      end
      default: ;
    endcase
  end

  // clip store: registered read, valid bits stand for the clear value
  always_ff @(posedge clk_i) begin
    if (rd_adv && issue_ok) begin
      rd_top_q <= top_mem[issue_x_q[CW-1:0]];
      rd_bot_q <= bot_mem[issue_x_q[CW-1:0]];
    end
    if (b_fire) begin
      top_mem[b_x_q[CW-1:0]] <= new_top;
      bot_mem[b_x_q[CW-1:0]] <= new_bot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      b_vld_q   <= 1'b0;
      clr_top_q <= RST_TOP;
      clr_bot_q <= RST_BOT;
    end else begin
      if (cmd_pop_o && (cmd_i.kind == swsc_pkg::KIND_CLEAR)) begin
        vld_q     <= '0;
        clr_top_q <= (cfg_top_i > ROW_MAX) ? ROW_MAX : cfg_top_i;
        clr_bot_q <= (cfg_bottom_i > ROW_MAX) ? ROW_MAX : cfg_bottom_i;
      end
      if (b_fire) begin
        vld_q[b_x_q[CW-1:0]] <= 1'b1;
      end
      if (rd_adv) begin
        b_vld_q <= issue_ok;
        if (issue_ok) begin
          rd_vld_q <= vld_q[issue_x_q[CW-1:0]];
        end
      end
    end
  end

endmodule

FILE: tb/tb_two_sided_wall_span_clipper.sv
module tb_two_sided_wall_span_clipper;
  timeunit 1ns;
  timeprecision 1ps;

  import swsc_pkg::*;

  localparam int unsigned NCOL = COLUMNS_DEF;
  localparam int unsigned NROW = ROWS_DEF;
  localparam int unsigned FRAC = FRACTION_BITS_DEF;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int SETTLE_CYCLES = 600;
  localparam int STALL_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_item_t item_i = '0;
  logic empty;
  logic pop = 1'b0;
  result_t result_o;
  logic valid = 1'b0;
  logic ready;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  two_sided_wall_span_clipper uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full), .item_i(item_i),
    .empty(empty), .pop(pop), .result_o(result_o),
    .valid(valid), .ready(ready), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // shadow of the clip store and edge registers
  logic [7:0] clear_top_reg = CLEAR_TOP_RESET;
  logic [7:0] clear_bottom_reg = CLEAR_BOTTOM_RESET;
  logic [7:0] col_top [NCOL];
  logic [7:0] col_bottom [NCOL];
  longint edge_start_y [4];
  longint edge_end_y [4];
  result_t column_records [$];

  int errors = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int hold_cycles = 0;

  function automatic logic [7:0] limit_row(logic [7:0] v);
    return (v > NROW - 1) ? 8'(NROW - 1) : v;
  endfunction

  function automatic longint clampv(longint v, longint lo, longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic void clear_clip_store();
    for (int i = 0; i < NCOL; i++) begin
      col_top[i] = limit_row(clear_top_reg);
      col_bottom[i] = limit_row(clear_bottom_reg);
    end
  endfunction

  function automatic void predict_columns(in_item_t it);
    longint width, adv, d, top, bot, cya, cnya, cyb, cnyb;
    longint slope [4];
    longint pos [4];
    int left, right, stop;
    result_t r;
    case (it.kind)
      KIND_CLEAR: clear_clip_store();
      KIND_LOAD: begin
        edge_start_y[it.edge_index] = longint'(it.edge_start_y);
        edge_end_y[it.edge_index] = longint'(it.edge_end_y);
      end
      KIND_SPAN: begin
        width = longint'(it.span_right) - longint'(it.span_left);
        left = it.draw_left;
        right = it.draw_right;
        adv = longint'(left) - longint'(it.span_left);
        for (int e = 0; e < 4; e++) begin
          d = edge_end_y[e] - edge_start_y[e];
          slope[e] = (width != 0) ? d / width : 0;
          pos[e] = edge_start_y[e] + slope[e] * adv;
        end
        stop = (right < NCOL) ? right : NCOL;
        for (int x = left; x < stop; x++) begin
          top = col_top[x];
          bot = col_bottom[x];
          cya = clampv(pos[0] >>> FRAC, top, bot);
          cnya = clampv(pos[1] >>> FRAC, top, bot);
          cyb = clampv(pos[2] >>> FRAC, top, bot);
          cnyb = clampv(pos[3] >>> FRAC, top, bot);
          if (cnyb < cya) cnyb = cya;
          if (cnya > cyb) cnya = cyb;
          col_top[x] = 8'(clampv((cya > cnya) ? cya : cnya, top, NROW - 1));
          col_bottom[x] = 8'(clampv((cyb < cnyb) ? cyb : cnyb, 0, bot));
          r.column = 6'(x);
          r.ceiling_top = 8'(top);
          r.ceiling_end = 8'(cya);
          r.upper_step_end = 8'(cnya);
          r.lower_step_start = 8'(cnyb);
          r.floor_start = 8'(cyb);
          r.floor_end = 8'(bot);
          r.border = (x == left || x == right - 1 || x == 0 || x == NCOL - 1);
          r.last = (x == stop - 1);
          column_records.push_back(r);
          for (int e = 0; e < 4; e++) pos[e] += slope[e];
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    item_i <= it;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_columns(it);
    burst_left--;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (column_records.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!ready) @(posedge clk_i);
    valid <= 1'b0;
    if (idx == CFG_CLEAR_TOP) clear_top_reg = data;
    else if (idx == CFG_CLEAR_BOTTOM) clear_bottom_reg = data;
  endtask

  function automatic in_item_t noise_item();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return in_item_t'(r[$bits(in_item_t)-1:0]);
  endfunction

  function automatic in_item_t load_item(edge_e e, bit wild);
    in_item_t it;
    it = noise_item();
    it.kind = KIND_LOAD;
    it.edge_index = e;
    if (!wild) begin
      it.edge_start_y = ($urandom_range(0, 240) - 40) * 4096 + $urandom_range(0, 4095);
      it.edge_end_y = ($urandom_range(0, 240) - 40) * 4096 + $urandom_range(0, 4095);
    end
    return it;
  endfunction

  function automatic in_item_t span_item(bit wild);
    in_item_t it;
    int dl;
    it = noise_item();
    it.kind = KIND_SPAN;
    if (!wild) begin
      dl = $urandom_range(0, NCOL - 1);
      it.draw_left = 7'(dl);
      it.draw_right = 7'(dl + $urandom_range(1, 8));
      it.span_left = 16'(dl - $urandom_range(0, 20));
      it.span_right = 16'(it.span_left + $urandom_range(0, 80));
    end else if ($urandom_range(0, 1)) begin
      it.draw_right = 7'(it.draw_left + $urandom_range(0, 6));
    end
    return it;
  endfunction

  task automatic load_all_edges(bit wild);
    send_item(load_item(EDGE_FRONT_CEIL, wild));
    send_item(load_item(EDGE_BACK_CEIL, wild));
    send_item(load_item(EDGE_FRONT_FLOOR, wild));
    send_item(load_item(EDGE_BACK_FLOOR, wild));
  endtask

  task automatic send_random(int count);
    in_item_t it;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        it = noise_item();
        it.kind = KIND_CLEAR;
      end else if (pick < 40) begin
        it = load_item(edge_e'($urandom_range(0, 3)), $urandom_range(0, 9) < 2);
      end else if (pick < 95) begin
        it = span_item($urandom_range(0, 9) < 2);
      end else begin
        it = noise_item();
        it.kind = kind_e'(KIND_UNUSED);
      end
      send_item(it);
    end
  endtask

  task automatic test_directed();
    in_item_t it;
    it = load_item(EDGE_FRONT_CEIL, 1'b0);
    it.edge_start_y = 32'sh7fffffff;
    it.edge_end_y = 32'sh80000000;
    send_item(it);
    it = load_item(EDGE_BACK_CEIL, 1'b0);
    it.edge_start_y = 32'sh80000000;
    it.edge_end_y = 32'sh7fffffff;
    send_item(it);
    send_item(load_item(EDGE_FRONT_FLOOR, 1'b0));
    send_item(load_item(EDGE_BACK_FLOOR, 1'b0));
    // whole screen, wide span
    it = span_item(1'b0);
    it.draw_left = 7'd0;
    it.draw_right = 7'd64;
    it.span_left = 16'sh8000;
    it.span_right = 16'sh7fff;
    send_item(it);
    // zero width
    it = span_item(1'b0);
    it.span_right = it.span_left;
    send_item(it);
    // draw range beyond the store
    it = span_item(1'b0);
    it.draw_left = 7'd60;
    it.draw_right = 7'd127;
    send_item(it);
    // empty draw range
    it = span_item(1'b0);
    it.draw_left = 7'd30;
    it.draw_right = 7'd30;
    send_item(it);
    it.draw_left = 7'd100;
    it.draw_right = 7'd120;
    send_item(it);
    it = noise_item();
    it.kind = kind_e'(KIND_UNUSED);
    send_item(it);
    load_all_edges(1'b0);
    for (int i = 0; i < 4; i++) send_item(span_item(1'b0));
    it = noise_item();
    it.kind = KIND_CLEAR;
    send_item(it);
    send_item(span_item(1'b0));
  endtask

  task automatic test_config_settings();
    in_item_t it;
    logic [7:0] tops [4] = '{8'd0, 8'd159, 8'd255, 8'd20};
    logic [7:0] bots [4] = '{8'd159, 8'd0, 8'd255, 8'd140};
    for (int s = 0; s < 4; s++) begin
      cfg_write(CFG_CLEAR_TOP, tops[s]);
      cfg_write(CFG_CLEAR_BOTTOM, bots[s]);
      cfg_write(CFG_UNUSED_IDX, 8'($urandom));
      it = noise_item();
      it.kind = KIND_CLEAR;
      send_item(it);
      load_all_edges(1'b0);
      send_random(12);
    end
    cfg_write(CFG_CLEAR_TOP, CLEAR_TOP_RESET);
    cfg_write(CFG_CLEAR_BOTTOM, CLEAR_BOTTOM_RESET);
  endtask

  task automatic test_backpressure();
    hold_cycles = 500;
    no_gaps = 1'b1;
    for (int i = 0; i < 8; i++) send_item(span_item(1'b0));
    no_gaps = 1'b0;
    wait_drained();
    send_random(10);
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // result side: check every transfer, stall in phases
  int stall_phase = 0;
  int phase_left = 0;
  always @(posedge clk_i) begin
    result_t e;
    if (pop && !empty) begin
      if (column_records.size() == 0) begin
        $error("column record with nothing expected: column %0d", result_o.column);
        errors++;
      end else begin
        e = column_records.pop_front();
        check_field("column", e.column, result_o.column);
        check_field("ceiling_top", e.ceiling_top, result_o.ceiling_top);
        check_field("ceiling_end", e.ceiling_end, result_o.ceiling_end);
        check_field("upper_step_end", e.upper_step_end, result_o.upper_step_end);
        check_field("lower_step_start", e.lower_step_start, result_o.lower_step_start);
        check_field("floor_start", e.floor_start, result_o.floor_start);
        check_field("floor_end", e.floor_end, result_o.floor_end);
        check_field("border", e.border, result_o.border);
        check_field("last", e.last, result_o.last);
      end
    end
    if (phase_left == 0) begin
      stall_phase = $urandom_range(0, 2);
      phase_left = $urandom_range(10, 80);
    end else begin
      phase_left--;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      pop <= 1'b0;
    end else begin
      case (stall_phase)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 1) == 1);
        default: pop <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  int idle_count = 0;
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (valid && ready)) begin
      idle_count <= 0;
    end else if (idle_count >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    clear_clip_store();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_settings();
    test_backpressure();
    load_all_edges(1'b0);
    send_random(220);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && column_records.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
